@@ src/s2h_pkg.sv @@
package s2h_pkg;

    // Field widths of the two number formats.
    localparam int SINGLE_W = 32;
    localparam int HALF_W   = 16;
    localparam int S_EXP_W  = 8;
    localparam int S_FRAC_W = 23;
    localparam int H_EXP_W  = 5;
    localparam int H_FRAC_W = 10;
    localparam int MAG_W    = H_FRAC_W + 1;
    localparam int SHIFT_W  = 5;

    // Exponent thresholds and rounding constants.
    localparam logic [S_EXP_W-1:0]  S_EXP_ALL_ONES   = 8'hFF;
    localparam logic [S_EXP_W-1:0]  EXP_REBIAS       = 8'd112;
    localparam logic [S_EXP_W-1:0]  EXP_OVERFLOW     = 8'd143;
    localparam logic [S_EXP_W-1:0]  EXP_UNDERFLOW    = 8'd103;
    localparam logic [S_EXP_W-1:0]  SUBNORMAL_BASE   = 8'd126;
    localparam logic [S_FRAC_W:0]   NORMAL_ROUND_ADD = 24'h001000;
    localparam logic [H_EXP_W-1:0]  HALF_EXP_MAX     = 5'h1F;
    localparam logic [H_FRAC_W-1:0] HALF_QUIET_BIT   = 10'h200;

    // Class of an input value, decided in the first stage.
    localparam logic [2:0] CLS_ZERO = 3'd0;
    localparam logic [2:0] CLS_SUB  = 3'd1;
    localparam logic [2:0] CLS_NORM = 3'd2;
    localparam logic [2:0] CLS_OVF  = 3'd3;
    localparam logic [2:0] CLS_NAN  = 3'd4;

    // Contents of the first pipeline register.
    typedef struct packed {
        logic                sign;
        logic [2:0]          cls;
        logic [S_EXP_W-1:0]  exp;
        logic [S_FRAC_W-1:0] frac;
    } t_s1;

    // Contents of the second pipeline register.
    typedef struct packed {
        logic               sign;
        logic [2:0]         cls;
        logic [H_EXP_W-1:0] hexp;
        logic [MAG_W-1:0]   mag;
    } t_s2;

endpackage

@@ src/s2h_decode.sv @@
module s2h_decode
    import s2h_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [SINGLE_W-1:0] i_single_bits,
    output t_s1                 o_q
);

    logic [S_EXP_W-1:0] w_exp;
    t_s1                n_q;
    t_s1                r_q;

    assign w_exp = i_single_bits[SINGLE_W-2 -: S_EXP_W];

    // Split the fields and sort the exponent into its range.
    always_comb begin
        n_q.sign = i_single_bits[SINGLE_W-1];
        n_q.exp  = w_exp;
        n_q.frac = i_single_bits[S_FRAC_W-1:0];
        if (w_exp == S_EXP_ALL_ONES) begin
            n_q.cls = CLS_NAN;
        end else if (w_exp < EXP_UNDERFLOW) begin
            n_q.cls = CLS_ZERO;
        end else if (w_exp <= EXP_REBIAS) begin
            n_q.cls = CLS_SUB;
        end else if (w_exp >= EXP_OVERFLOW) begin
            n_q.cls = CLS_OVF;
        end else begin
            n_q.cls = CLS_NORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ src/s2h_align.sv @@
module s2h_align
    import s2h_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_s1  i_d,
    output t_s2  o_q
);

    logic [S_FRAC_W:0]  w_sig;
    logic [S_FRAC_W:0]  w_sum;
    logic [S_FRAC_W:0]  w_shifted;
    logic [SHIFT_W-1:0] w_shamt;
    t_s2                n_q;
    t_s2                r_q;

    // Subnormal: shift one place short so the round bit stays as the LSB.
    assign w_sig     = {1'b1, i_d.frac};
    assign w_shamt   = SHIFT_W'(SUBNORMAL_BASE - 8'd1 - i_d.exp);
    assign w_shifted = w_sig >> w_shamt;

    // Normal: add half an output LSB before truncation.
    assign w_sum = {1'b0, i_d.frac} + NORMAL_ROUND_ADD;

    always_comb begin
        n_q.sign = i_d.sign;
        n_q.cls  = i_d.cls;
        n_q.hexp = H_EXP_W'(i_d.exp - EXP_REBIAS);
        case (i_d.cls)
            CLS_SUB: begin
                n_q.mag = w_shifted[MAG_W-1:0];
            end
            CLS_NORM: begin
                n_q.mag = w_sum[S_FRAC_W -: MAG_W];
            end
            CLS_NAN: begin
                // Infinity keeps a zero fraction; NaN becomes quiet.
                if (i_d.frac != '0) begin
                    n_q.mag = {1'b0, HALF_QUIET_BIT | i_d.frac[S_FRAC_W-1 -: H_FRAC_W]};
                end else begin
                    n_q.mag = '0;
                end
            end
            default: begin
                n_q.mag = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

@@ src/s2h_pack.sv @@
module s2h_pack
    import s2h_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  t_s2               i_d,
    output logic [HALF_W-1:0] o_half_bits
);

    logic [MAG_W-1:0]   w_sub_mag;
    logic [H_EXP_W-1:0] w_exp_inc;
    logic [HALF_W-1:0]  n_half;
    logic [HALF_W-1:0]  r_half;

    // Subnormal rounding; a carry into bit 10 gives the smallest normal.
    assign w_sub_mag = {1'b0, i_d.mag[MAG_W-1:1]} + MAG_W'(i_d.mag[0]);

    // Exponent bump on a mantissa carry, saturating at infinity.
    assign w_exp_inc = (i_d.hexp >= HALF_EXP_MAX - 5'd1) ? HALF_EXP_MAX : i_d.hexp + 5'd1;

    always_comb begin
        case (i_d.cls)
            CLS_SUB: begin
                n_half = {i_d.sign, 4'b0, w_sub_mag};
            end
            CLS_NORM: begin
                if (i_d.mag[MAG_W-1]) begin
                    n_half = {i_d.sign, w_exp_inc, {H_FRAC_W{1'b0}}};
                end else begin
                    n_half = {i_d.sign, i_d.hexp, i_d.mag[H_FRAC_W-1:0]};
                end
            end
            CLS_OVF: begin
                n_half = {i_d.sign, HALF_EXP_MAX, {H_FRAC_W{1'b0}}};
            end
            CLS_NAN: begin
                n_half = {i_d.sign, HALF_EXP_MAX, i_d.mag[H_FRAC_W-1:0]};
            end
            default: begin
                n_half = {i_d.sign, {(HALF_W-1){1'b0}}};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_half <= n_half;
        end
    end

    assign o_half_bits = r_half;

endmodule

@@ src/single_to_half_convert.sv @@
// Converts IEEE binary32 bit patterns to binary16 bit patterns.
// Input channel: i_valid, i_single_bits, with o_stall driven back to the sender.
// Output channel: o_valid, o_half_bits, with i_stall driven by the receiver.
// A transaction completes on a rising edge where valid is high and stall is low.
// The datapath has three register stages: decode, align and round, pack.
// The last stage is the output register; an accepted input passes the decode
// register and the align register before its result is visible there.
// Throughput is one transaction per cycle while i_stall is low; each stage holds
// one item and moves forward whenever the stage after it is empty or moving.
// When the receiver stalls, the output register holds its value and the
// stall backs up stage by stage; empty stages still fill, so up to three
// items are held before o_stall rises. Nothing is dropped or repeated.
// Reset (synchronous, active low) clears the stage valid bits only; the data
// registers are not reset. The block is ready on the first cycle after reset.
module single_to_half_convert
    import s2h_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SINGLE_W-1:0] i_single_bits,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [HALF_W-1:0]   o_half_bits
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;
    t_s1  w_s1;
    t_s2  w_s2;

    // A stage may load when it is empty or its content moves on.
    assign w_adv3  = !r_v3 || !i_stall;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;
    assign o_valid = r_v3;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    s2h_decode u_decode (
        .i_clk         (i_clk),
        .i_en          (w_adv1 && i_valid),
        .i_single_bits (i_single_bits),
        .o_q           (w_s1)
    );

    s2h_align u_align (
        .i_clk (i_clk),
        .i_en  (w_adv2 && r_v1),
        .i_d   (w_s1),
        .o_q   (w_s2)
    );

    s2h_pack u_pack (
        .i_clk       (i_clk),
        .i_en        (w_adv3 && r_v2),
        .i_d         (w_s2),
        .o_half_bits (o_half_bits)
    );

endmodule

@@ src/s2h_checker.sv @@
module s2h_checker
    import s2h_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [HALF_W-1:0] o_half_bits
);

    // The output is empty on the cycle after a reset cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // With the output register empty, every stage can move, so no back-pressure.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output is empty");

    // An accepted transaction reaches the output while the receiver does not stall.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall [*2] |=> o_valid)
        else $error("accepted transaction did not reach the output in time");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_half_bits)))
        else $error("stalled output changed");

endmodule

bind single_to_half_convert s2h_checker u_s2h_checker (.*);
